// File: sv/msb_first_bit_packer_core_defines.svh
// Assertion macros used by the bit packer core.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef MSB_FIRST_BIT_PACKER_CORE_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_CORE_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define MFBP_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bit packer check failed");

// Consequence must hold in the cycle after the antecedent.
`define MFBP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bit packer check failed");

`endif

// File: sv/mfbp_pkg.sv
package mfbp_pkg;

    // Operation codes of an input beat.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Longest code that a write may carry.
    localparam logic [6:0] LEN_MAX = 7'd64;

    // One input beat.
    typedef struct packed {
        logic        op;
        logic [63:0] code_bits;
        logic [6:0]  code_length;
    } mfbp_in_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_chunk;
        logic       last;
        logic       error;
    } mfbp_out_t;

    // Outcome of one pass through the byte merge unit.
    typedef struct packed {
        logic [7:0] byte_out;
        logic [7:0] new_partial;
        logic [2:0] new_filled;
        logic [3:0] take;
        logic       byte_done;
    } mfbp_step_t;

endpackage

// File: sv/mfbp_step.sv
module mfbp_step (
    input  logic [7:0]          partial,
    input  logic [2:0]          filled,
    input  logic [6:0]          rem,
    input  logic [7:0]          window,
    output mfbp_pkg::mfbp_step_t step
);
    import mfbp_pkg::*;

    logic [3:0] free_bits;
    logic [3:0] take;
    logic [7:0] keep_mask;
    logic [7:0] merged;
    logic [3:0] fill_sum;

    // Take as many of the top code bits as fit into the open byte.
    assign free_bits = 4'd8 - {1'b0, filled};
    assign take      = (rem < {3'b000, free_bits}) ? rem[3:0] : free_bits;
    assign keep_mask = ~(8'hFF >> take);
    assign merged    = partial | ((window & keep_mask) >> filled);
    assign fill_sum  = {1'b0, filled} + take;

    // A full byte leaves the unit and the open byte starts empty again.
    always_comb
    begin
        step.byte_out    = merged;
        step.byte_done   = fill_sum[3];
        step.new_partial = fill_sum[3] ? 8'h00 : merged;
        step.new_filled  = fill_sum[2:0];
        step.take        = take;
    end

endmodule

// File: sv/mfbp_out_reg.sv
module mfbp_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mfbp_pkg::mfbp_out_t push_data,
    output logic                can_push,
    output logic                result_valid,
    input  logic                result_ready,
    output mfbp_pkg::mfbp_out_t result
);
    import mfbp_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    mfbp_out_t data_reg;

    // The slot is free when empty or when its beat leaves this cycle.
    assign can_push     = !valid_reg || result_ready;
    assign result_valid = valid_reg;
    assign result       = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Valid flag under reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload holds until a new beat is pushed.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= push_data;
        end
    end

endmodule

// File: sv/msb_first_bit_packer_core.sv
// Packs variable-length codes into bytes, most significant bit first. A write
// beat is taken while idle, after which a byte-wide merge unit moves up to
// eight code bits per cycle into the open byte and hands out one result per
// completed byte. A write takes one merge step per byte it completes, and one
// more when it completes no byte or leaves bits in the open byte. A flush or
// a rejected write takes a single merge step.
// The rate is set by that single merge unit, one byte per cycle, and the
// block takes no new beat until the current one is done. Results sit in a
// one-beat output register; a stalled result holds the merge unit.
// Every CHUNK_BYTES bytes the closing byte is marked end_of_chunk, and a
// flush closes the chunk and clears the open byte and the chunk count.
`include "msb_first_bit_packer_core_defines.svh"

module msb_first_bit_packer_core #(
    parameter int CHUNK_BYTES = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  mfbp_pkg::mfbp_in_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output mfbp_pkg::mfbp_out_t result
);
    import mfbp_pkg::*;

    localparam int CNT_W = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CHUNK_BYTES - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WORK = 2'b10
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic             op_reg;
    logic             op_next;
    logic             err_reg;
    logic             err_next;
    logic [63:0]      code_reg;
    logic [63:0]      code_next;
    logic [6:0]       rem_reg;
    logic [6:0]       rem_next;
    logic [7:0]       partial_reg;
    logic [7:0]       partial_next;
    logic [2:0]       filled_reg;
    logic [2:0]       filled_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    logic             can_push;
    logic             push;
    mfbp_out_t        push_data;
    mfbp_step_t       step;
    logic [6:0]       rem_after;
    logic             flush_step;
    logic             err_step;
    logic             chunk_end;

    // Byte merge unit, fed with the top eight bits of the aligned code.
    mfbp_step u_step (
        .partial (partial_reg),
        .filled  (filled_reg),
        .rem     (rem_reg),
        .window  (code_reg[63:56]),
        .step    (step)
    );

    // One-beat output register.
    mfbp_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_data    (push_data),
        .can_push     (can_push),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    assign item_ready = (state_reg == ST_IDLE);
    assign flush_step = (state_reg == ST_WORK) && can_push && (op_reg == OP_FLUSH);
    assign err_step   = (state_reg == ST_WORK) && can_push && (op_reg == OP_WRITE)
                        && err_reg;
    assign rem_after  = rem_reg - {3'b000, step.take};
    assign chunk_end  = (cnt_reg == CNT_LAST);

    // Sequencer: take a beat, then step the merge unit once per cycle while the output slot has room.
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        err_next     = err_reg;
        code_next    = code_reg;
        rem_next     = rem_reg;
        partial_next = partial_reg;
        filled_next  = filled_reg;
        cnt_next     = cnt_reg;
        push         = 1'b0;
        push_data    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    // Left-align the code so that its first bit sits at bit 63.
                    op_next    = item.op;
                    err_next   = (item.code_length > LEN_MAX);
                    code_next  = item.code_bits << (LEN_MAX - item.code_length);
                    rem_next   = item.code_length;
                    state_next = ST_WORK;
                end
            end
            ST_WORK:
            begin
                if (can_push)
                begin
                    if (op_reg == OP_FLUSH)
                    begin
                        push                   = 1'b1;
                        push_data.data_byte    = partial_reg;
                        push_data.byte_present = (filled_reg != 3'd0);
                        push_data.end_of_chunk = 1'b1;
                        push_data.last         = 1'b1;
                        partial_next           = 8'h00;
                        filled_next            = 3'd0;
                        cnt_next               = '0;
                        state_next             = ST_IDLE;
                    end
                    else if (err_reg)
                    begin
                        push            = 1'b1;
                        push_data.error = 1'b1;
                        push_data.last  = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        partial_next = step.new_partial;
                        filled_next  = step.new_filled;
                        rem_next     = rem_after;
                        code_next    = code_reg << step.take;
                        if (step.byte_done)
                        begin
                            push                   = 1'b1;
                            push_data.data_byte    = step.byte_out;
                            push_data.byte_present = 1'b1;
                            push_data.end_of_chunk = chunk_end;
                            push_data.last         = (rem_after < 7'd8);
                            cnt_next = chunk_end ? '0 : cnt_reg + CNT_W'(1);
                        end
                        if (!step.byte_done || (rem_after == 7'd0))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and packing state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            partial_reg <= 8'h00;
            filled_reg  <= 3'd0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            partial_reg <= partial_next;
            filled_reg  <= filled_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Working copy of the current beat.
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        err_reg  <= err_next;
        code_reg <= code_next;
        rem_reg  <= rem_next;
    end

    // A result is only pushed when the output slot can take it.
    `MFBP_ASSERT_NOW(a_push_has_room, push, can_push)
    // A flush leaves the packer empty and the chunk count at zero.
    `MFBP_ASSERT_NEXT(a_flush_clears, flush_step,
        (filled_reg == 3'd0) && (partial_reg == 8'h00) && (cnt_reg == '0))
    // A rejected write leaves the packing state untouched.
    `MFBP_ASSERT_NEXT(a_error_keeps_state, err_step,
        $stable(filled_reg) && $stable(partial_reg) && $stable(cnt_reg))
    // An error result carries no byte and ends its beat.
    `MFBP_ASSERT_NOW(a_error_result, result_valid && result.error,
        result.last && !result.byte_present && !result.end_of_chunk)

endmodule

// File: bench/msb_first_bit_packer_core_tb.sv
module msb_first_bit_packer_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mfbp_pkg::*;

    localparam int CHUNK        = 256;
    localparam int RANDOM_ITEMS = 400;
    localparam int LIMIT_CYCLES = 300000;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 20;

    // One input beat waiting to be offered, optionally held back until the
    // output side has drained completely.
    typedef struct {
        mfbp_in_t beat;
        bit       drain_first;
    } pending_t;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_ready;
    mfbp_in_t  item         = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    mfbp_out_t result;

    pending_t  pending_beats[$];
    mfbp_out_t expected_results[$];

    int        total_items    = 0;
    int        items_accepted = 0;
    int        mismatch_count = 0;
    int        cycle_count    = 0;

    // Sender burst shaping.
    int        burst_left = 0;
    int        gap_left   = 0;

    // Receiver stall pattern.
    int        stall_mode     = 0;
    int        mode_cycles    = 0;
    int        stall_phase    = 0;
    int        hold_left      = 0;
    bit        long_hold_done = 1'b0;

    // Packer state as the testbench sees it.
    logic [7:0] open_byte       = '0;
    int         open_bits       = 0;
    int         chunk_byte_tally = 0;

    msb_first_bit_packer_core #(
        .CHUNK_BYTES (CHUNK)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #1 clk = ~clk;

    // Works out the result beats that one accepted input beat causes and
    // advances the packer state.
    task automatic pack_beat(input mfbp_in_t beat);
        mfbp_out_t made[$];
        mfbp_out_t r;
        int        len;
        len = int'(beat.code_length);
        if (beat.op == OP_FLUSH)
        begin
            r = '0;
            r.byte_present = (open_bits != 0);
            r.data_byte    = (open_bits != 0) ? open_byte : 8'h00;
            r.end_of_chunk = 1'b1;
            made.push_back(r);
            open_byte        = '0;
            open_bits        = 0;
            chunk_byte_tally = 0;
        end
        else if (beat.code_length > LEN_MAX)
        begin
            r = '0;
            r.error = 1'b1;
            made.push_back(r);
        end
        else
        begin
            for (int i = len - 1; i >= 0; i--)
            begin
                if (beat.code_bits[i])
                    open_byte[7 - open_bits] = 1'b1;
                open_bits++;
                if (open_bits == 8)
                begin
                    r = '0;
                    r.data_byte    = open_byte;
                    r.byte_present = 1'b1;
                    chunk_byte_tally++;
                    if (chunk_byte_tally >= CHUNK)
                    begin
                        r.end_of_chunk   = 1'b1;
                        chunk_byte_tally = 0;
                    end
                    made.push_back(r);
                    open_byte = '0;
                    open_bits = 0;
                end
            end
        end
        if (made.size() != 0)
            made[made.size() - 1].last = 1'b1;
        foreach (made[k])
            expected_results.push_back(made[k]);
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    function automatic mfbp_in_t make_beat(input logic op, input logic [63:0] bits,
                                           input int len);
        mfbp_in_t b;
        b.op          = op;
        b.code_bits   = bits;
        b.code_length = len[6:0];
        return b;
    endfunction

    task automatic add_beat(input mfbp_in_t beat, input bit drain_first);
        pending_t p;
        p.beat        = beat;
        p.drain_first = drain_first;
        pending_beats.push_back(p);
        total_items++;
    endtask

    // Random write, lengths weighted towards the edges of the legal range,
    // with the occasional over-long code.
    function automatic mfbp_in_t random_write(input bit wide);
        int sel;
        int len;
        sel = $urandom_range(0, 19);
        if (wide)
            len = $urandom_range(40, 64);
        else if (sel == 0)
            len = $urandom_range(65, 127);
        else if (sel == 1)
            len = 0;
        else if (sel <= 3)
            len = 64;
        else if (sel <= 9)
            len = $urandom_range(1, 8);
        else
            len = $urandom_range(0, 64);
        return make_beat(OP_WRITE, {$urandom(), $urandom()}, len);
    endfunction

    // Driver: offers pending beats in bursts separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin : driver
        pending_t nxt;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                pack_beat(item);
                items_accepted++;
            end
            if (!(item_valid && !item_ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (pending_beats.size() != 0 &&
                         !(pending_beats[0].drain_first && expected_results.size() != 0))
                begin
                    nxt = pending_beats.pop_front();
                    item       <= nxt.beat;
                    item_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: a stall pattern that changes every so often, plus one long
    // hold-off once traffic is under way.
    always @(posedge clk or negedge rst_n)
    begin : receiver
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            mode_cycles++;
            stall_phase++;
            if (mode_cycles >= 50)
            begin
                mode_cycles = 0;
                stall_mode  = $urandom_range(0, 3);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (!long_hold_done && items_accepted >= 60)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
                result_ready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0: result_ready <= 1'b1;
                    1: result_ready <= 1'($urandom_range(0, 1));
                    2: result_ready <= ($urandom_range(0, 7) != 0);
                    default: result_ready <= ((stall_phase % 9) < 3);
                endcase
            end
        end
    end

    // Monitor: every accepted result beat is checked against the oldest
    // expectation.
    always @(posedge clk)
    begin : monitor
        mfbp_out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result beat with none expected");
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("data_byte", int'(result.data_byte), int'(want.data_byte));
                check_field("byte_present", int'(result.byte_present),
                            int'(want.byte_present));
                check_field("end_of_chunk", int'(result.end_of_chunk),
                            int'(want.end_of_chunk));
                check_field("last", int'(result.last), int'(want.last));
                check_field("error", int'(result.error), int'(want.error));
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : stimulus
        int seg;
        int seg_len;
        int random_count;

        // Directed beats: empty and full-width codes, partial bytes, flushes
        // with and without pending bits, rejected lengths that must leave
        // the open byte alone, and a write that completes eight bytes.
        add_beat(make_beat(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 0), 1'b0);
        add_beat(make_beat(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 64), 1'b0);
        add_beat(make_beat(OP_WRITE, 64'h0000_0000_0000_0000, 64), 1'b0);
        add_beat(make_beat(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFD, 3), 1'b0);
        add_beat(make_beat(OP_FLUSH, 64'h0, 0), 1'b0);
        add_beat(make_beat(OP_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 127), 1'b0);
        add_beat(make_beat(OP_WRITE, 64'h0000_0000_0000_0015, 5), 1'b0);
        add_beat(make_beat(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 127), 1'b0);
        add_beat(make_beat(OP_WRITE, 64'h0000_0000_0000_0000, 65), 1'b0);
        add_beat(make_beat(OP_WRITE, 64'h0000_0000_0000_0006, 3), 1'b0);
        for (int i = 0; i < 8; i++)
            add_beat(make_beat(OP_WRITE, {63'h0, i[0]}, 1), 1'b0);
        add_beat(make_beat(OP_WRITE, 64'h0000_0000_0000_000B, 4), 1'b1);
        add_beat(make_beat(OP_WRITE, 64'h8000_0000_0000_0001, 64), 1'b0);
        add_beat(make_beat(OP_WRITE, 64'hAAAA_AAAA_AAAA_AAAA, 64), 1'b0);
        add_beat(make_beat(OP_WRITE, 64'h5555_5555_5555_557F, 7), 1'b0);
        add_beat(make_beat(OP_FLUSH, 64'h0, 64), 1'b0);

        // Random part: runs of writes closed by a flush. The first run is
        // long and wide so that chunk boundaries are crossed.
        seg          = 0;
        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            seg_len = (seg == 0) ? 90 : $urandom_range(1, 60);
            if (seg_len > RANDOM_ITEMS - random_count)
                seg_len = RANDOM_ITEMS - random_count;
            for (int k = 0; k < seg_len; k++)
            begin
                add_beat(random_write(seg == 0), (k == 0) && (seg % 4 == 0));
                random_count++;
            end
            add_beat(make_beat(OP_FLUSH, {$urandom(), $urandom()}, $urandom_range(0, 127)),
                     1'b0);
            random_count++;
            if ($urandom_range(0, 3) == 0)
            begin
                add_beat(make_beat(OP_FLUSH, {$urandom(), $urandom()}, 0), 1'b0);
                random_count++;
            end
            seg++;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (items_accepted < total_items)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/mfbp_pkg.sv
sv/mfbp_step.sv
sv/mfbp_out_reg.sv
sv/msb_first_bit_packer_core.sv
bench/msb_first_bit_packer_core_tb.sv
